// ----- design/first_fit_page_allocator_macros.svh -----
// ----------------------------------------------------------------------------
// first_fit_page_allocator_macros
// assertion macros for the page allocator, compiled out with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_PAGE_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_PAGE_ALLOCATOR_MACROS_SVH

`ifndef ASSERT_OFF
`define FFPA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define FFPA_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define FFPA_ASSERT(label, clk, rst, prop, msg)
`define FFPA_NEVER(label, clk, rst, cond, msg)
`endif

`endif

// ----- design/ffpa_pkg.sv -----
// ----------------------------------------------------------------------------
// ffpa_pkg
// types and constants shared by the page allocator and its region cells
// ----------------------------------------------------------------------------
`default_nettype none

package ffpa_pkg;

   localparam int MAX_REGIONS = 64;
   localparam int CNT_W       = $clog2(MAX_REGIONS + 1);

   localparam logic [63:0] PAGE_BYTES = 64'h1000;
   localparam logic [63:0] META_BYTES = 64'h2000;

   localparam logic       FUNC_LOAD  = 1'b0;
   localparam logic       FUNC_ALLOC = 1'b1;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_NO_PAGE = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;
   localparam logic [1:0] STATUS_NO_META = 2'd3;

   typedef struct packed {
      logic        func;
      logic [63:0] region_base;
      logic [31:0] region_pages;
      logic        region_free;
      logic        last_region;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] page_address;
      logic        meta_reserved;
   } rsp_type;

   // search token handed from cell to cell
   typedef struct packed {
      logic        active;
      logic        found;
      logic [63:0] addr;
   } scan_type;

   typedef enum logic [2:0] {
      FSM_IDLE = 3'b001,
      FSM_SCAN = 3'b010,
      FSM_DONE = 3'b100
   } fsm_type;

endpackage

`default_nettype wire

// ----- design/first_fit_page_allocator.sv -----
// ----------------------------------------------------------------------------
// first_fit_page_allocator: first-fit 4 KiB page allocator over a region table
// load: result in the cycle after accept; allocate: result once the token has walked every cell, one cell a cycle
// one item in flight: no new item is taken until the previous result has been accepted
// synchronous reset empties the table and clears the metadata flag at once
// ----------------------------------------------------------------------------
`default_nettype none
`include "first_fit_page_allocator_macros.svh"

module first_fit_page_allocator (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ffpa_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ffpa_pkg::rsp_type rsp_item
);
   import ffpa_pkg::*;

   fsm_type           state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              meta_ff, meta_in;
   rsp_type           rsp_ff, rsp_in;

   scan_type          chain [0:MAX_REGIONS];

   logic              accept;
   logic              reserve;
   logic [63:0]       eff_base;
   logic [31:0]       eff_pages;
   logic              store;
   logic              full;
   logic              wr_en;
   logic              meta_new;
   logic [1:0]        load_status;

   assign accept    = req_valid && !req_stall;
   assign req_stall = state_ff != FSM_IDLE;
   assign rsp_valid = state_ff == FSM_DONE;
   assign rsp_item  = rsp_ff;

   // load path
   assign reserve   = req_item.region_free && !meta_ff && (req_item.region_pages >= 32'd2);
   assign eff_base  = reserve ? req_item.region_base + META_BYTES : req_item.region_base;
   assign eff_pages = reserve ? req_item.region_pages - 32'd2 : req_item.region_pages;
   assign meta_new  = meta_ff || reserve;
   assign store     = req_item.region_free && (eff_pages != 32'd0);
   assign full      = count_ff == CNT_W'(MAX_REGIONS);
   assign wr_en     = accept && (req_item.func == FUNC_LOAD) && store && !full;

   always_comb begin
      load_status = STATUS_OK;
      if (store && full) begin
         load_status = STATUS_FULL;
      end
      if (req_item.last_region && !meta_new) begin
         load_status = STATUS_NO_META;
      end
   end

   // search token enters the first cell
   always_comb begin
      chain[0].active = accept && (req_item.func == FUNC_ALLOC);
      chain[0].found  = 1'b0;
      chain[0].addr   = 64'd0;
   end

   for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_cell
      ffpa_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cell_index  (CNT_W'(i)),
         .entry_count (count_ff),
         .wr_en       (wr_en),
         .wr_base     (eff_base),
         .wr_pages    (eff_pages),
         .scan_in     (chain[i]),
         .scan_out    (chain[i+1])
      );
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      meta_in  = meta_ff;
      rsp_in   = rsp_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               if (req_item.func == FUNC_LOAD) begin
                  meta_in = meta_new;
                  if (req_item.last_region && !meta_new) begin
                     count_in = '0;
                  end else if (wr_en) begin
                     count_in = count_ff + CNT_W'(1);
                  end
                  rsp_in.status        = load_status;
                  rsp_in.page_address  = 64'd0;
                  rsp_in.meta_reserved = meta_new;
                  state_in             = FSM_DONE;
               end else begin
                  state_in = FSM_SCAN;
               end
            end
         end
         FSM_SCAN: begin
            if (chain[MAX_REGIONS].active) begin
               rsp_in.status        = chain[MAX_REGIONS].found ? STATUS_OK : STATUS_NO_PAGE;
               rsp_in.page_address  = chain[MAX_REGIONS].found ? chain[MAX_REGIONS].addr
                                                               : 64'd0;
               rsp_in.meta_reserved = meta_ff;
               state_in             = FSM_DONE;
            end
         end
         FSM_DONE: begin
            if (!rsp_stall) begin
               state_in = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
         count_ff <= '0;
         meta_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         meta_ff  <= meta_in;
      end
      rsp_ff <= rsp_in;
   end

   `FFPA_NEVER(a_count_range, clock, reset, count_ff > CNT_W'(MAX_REGIONS), "table count overflow")
   `FFPA_ASSERT(a_token_in_scan, clock, reset, chain[MAX_REGIONS].active |-> state_ff == FSM_SCAN, "search token outside scan")
   `FFPA_NEVER(a_meta_sticky, clock, reset, $fell(meta_ff), "metadata flag cleared")
   `FFPA_ASSERT(a_scan_done, clock, reset, (state_ff == FSM_SCAN && chain[MAX_REGIONS].active) |=> state_ff == FSM_DONE, "scan end without result")

endmodule

`default_nettype wire

// ----- design/ffpa_cell.sv -----
// ----------------------------------------------------------------------------
// ffpa_cell
// one region table entry; if occupied with pages left, takes a page when an unfound search token reaches it
// ----------------------------------------------------------------------------
`default_nettype none

module ffpa_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [ffpa_pkg::CNT_W-1:0] cell_index,
   input  logic [ffpa_pkg::CNT_W-1:0] entry_count,
   input  logic                     wr_en,
   input  logic [63:0]              wr_base,
   input  logic [31:0]              wr_pages,
   input  ffpa_pkg::scan_type       scan_in,
   output ffpa_pkg::scan_type       scan_out
);
   import ffpa_pkg::*;

   logic [63:0] base_ff, base_in;
   logic [31:0] pages_ff, pages_in;
   scan_type    scan_ff, scan_in_nx;
   logic        occupied;
   logic        take;
   logic        wr_sel;

   assign occupied = cell_index < entry_count;
   assign wr_sel   = wr_en && (entry_count == cell_index);
   assign take     = scan_in.active && !scan_in.found && occupied && (pages_ff != 32'd0);

   always_comb begin
      base_in    = base_ff;
      pages_in   = pages_ff;
      scan_in_nx = scan_in;
      if (wr_sel) begin
         base_in  = wr_base;
         pages_in = wr_pages;
      end else if (take) begin
         base_in          = base_ff + PAGE_BYTES;
         pages_in         = pages_ff - 32'd1;
         scan_in_nx.found = 1'b1;
         scan_in_nx.addr  = base_ff;
      end
   end

   always_ff @(posedge clock) begin
      base_ff  <= base_in;
      pages_ff <= pages_in;
      if (reset) begin
         scan_ff <= '0;
      end else begin
         scan_ff <= scan_in_nx;
      end
   end

   assign scan_out = scan_ff;

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: first-fit page allocator testbench
// drives load and allocate items with random gaps and stalls on both sides,
// predicts every result from a private copy of the region table and checks
// each result field by field in arrival order
// ----------------------------------------------------------------------------

module tb;

   import ffpa_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 1_000_000;

   class page_alloc_scoreboard;
      logic [63:0] run_base [MAX_REGIONS];
      logic [31:0] run_pages [MAX_REGIONS];
      int unsigned run_count = 0;
      bit          meta_done = 0;
      rsp_type     expected_rsp [$];
      int unsigned mismatches = 0;

      function void record_request(req_type r);
         rsp_type     e;
         logic [63:0] base;
         logic [31:0] pages;
         bit          found;
         e = '0;
         found = 0;
         if (r.func == FUNC_LOAD) begin
            e.status = STATUS_OK;
            base = r.region_base;
            pages = r.region_pages;
            if (r.region_free) begin
               if (!meta_done && pages >= 2) begin
                  base = base + META_BYTES;
                  pages = pages - 2;
                  meta_done = 1;
               end
               if (pages != 0) begin
                  if (run_count < MAX_REGIONS) begin
                     run_base[run_count] = base;
                     run_pages[run_count] = pages;
                     run_count++;
                  end else begin
                     e.status = STATUS_FULL;
                  end
               end
            end
            if (r.last_region && !meta_done) begin
               run_count = 0;
               e.status = STATUS_NO_META;
            end
         end else begin
            e.status = STATUS_NO_PAGE;
            e.page_address = '0;
            for (int i = 0; i < run_count; i++) begin
               if (!found && run_pages[i] != 0) begin
                  found = 1;
                  e.status = STATUS_OK;
                  e.page_address = run_base[i];
                  run_base[i] = run_base[i] + PAGE_BYTES;
                  run_pages[i] = run_pages[i] - 1;
               end
            end
         end
         e.meta_reserved = meta_done;
         expected_rsp.push_back(e);
      endfunction

      function void check_result(rsp_type got);
         rsp_type e;
         if (expected_rsp.size() == 0) begin
            $error("result with none expected: status %0d page_address %0h meta_reserved %0d",
                   got.status, got.page_address, got.meta_reserved);
            mismatches++;
            return;
         end
         e = expected_rsp.pop_front();
         if (got.status !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, got.status);
            mismatches++;
         end
         if (got.page_address !== e.page_address) begin
            $error("page_address: expected %0h, actual %0h", e.page_address, got.page_address);
            mismatches++;
         end
         if (got.meta_reserved !== e.meta_reserved) begin
            $error("meta_reserved: expected %0d, actual %0d", e.meta_reserved,
                   got.meta_reserved);
            mismatches++;
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_item;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_item;

   page_alloc_scoreboard sb = new();
   int unsigned cycles = 0;
   int unsigned items_sent = 0;
   bit          no_idle = 0;

   first_fit_page_allocator uut (
      .clock,
      .reset,
      .req_valid,
      .req_stall,
      .req_item,
      .rsp_valid,
      .rsp_stall,
      .rsp_item
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
   end

   initial begin
      wait (cycles >= CYCLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic int pick_gap();
      int roll;
      if (no_idle) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [63:0] rand_base();
      logic [63:0] b;
      b = {$urandom(), $urandom()};
      if ($urandom_range(0, 3) != 0) b[11:0] = '0;
      return b;
   endfunction

   // entered just after a rising edge, returns at the edge that takes the item
   task automatic send_req(input req_type r);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_item = r;
      do @(posedge clock); while (req_stall);
      sb.record_request(r);
      items_sent++;
   endtask

   task automatic send_load(input logic [63:0] base, input logic [31:0] pages,
                            input logic free, input logic last);
      req_type r;
      r.func = FUNC_LOAD;
      r.region_base = base;
      r.region_pages = pages;
      r.region_free = free;
      r.last_region = last;
      send_req(r);
   endtask

   task automatic send_alloc();
      req_type r;
      r.func = FUNC_ALLOC;
      r.region_base = {$urandom(), $urandom()};
      r.region_pages = $urandom();
      r.region_free = 1'($urandom_range(0, 1));
      r.last_region = 1'($urandom_range(0, 1));
      send_req(r);
   endtask

   task automatic idle_sender();
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic wait_drained();
      while (sb.expected_rsp.size() != 0) @(posedge clock);
   endtask

   // result side
   initial begin
      int hold;
      rsp_stall = 1'b0;
      hold = 0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            rsp_stall = 1'b1;
            hold--;
         end else begin
            rsp_stall = 1'b0;
            hold = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_result(rsp_item);
      end
   end

   initial begin
      int  kind;
      int  boot_len;
      int  i;
      bit  big_placed;
      reset = 1'b1;
      req_valid = 1'b0;
      req_item = '0;
      big_placed = 0;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // empty table, skipped regions, single-page runs, missing metadata
      send_alloc();
      send_load(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0);
      send_load(64'h0, 32'h0, 1'b1, 1'b0);
      send_load(64'h0000_0000_0010_0000, 32'h1, 1'b1, 1'b0);
      send_load(64'hFFFF_FFFF_FFFF_F000, 32'h1, 1'b1, 1'b0);
      send_alloc();
      send_alloc();
      send_alloc();
      send_load(64'h0000_0000_0020_0000, 32'h1, 1'b1, 1'b0);
      send_load(64'h0, 32'hFFFF_FFFF, 1'b0, 1'b1);
      send_alloc();
      send_load(64'h0000_0000_0030_0000, 32'h1, 1'b1, 1'b1);
      send_alloc();
      send_load(64'h0, 32'h0, 1'b1, 1'b1);

      // load sequences that never find a metadata region, the first overfills
      for (int n_boot = 0; n_boot < 8; n_boot++) begin
         boot_len = (n_boot == 0) ? 100 : $urandom_range(3, 25);
         i = 0;
         while (i < boot_len || (n_boot == 0 && sb.run_count < MAX_REGIONS)) begin
            kind = (n_boot == 0) ? $urandom_range(1, 5) : $urandom_range(0, 9);
            if (kind < 3) send_alloc();
            else if (kind < 6) send_load(rand_base(), 32'h1, 1'b1, 1'b0);
            else if (kind == 6) send_load(rand_base(), 32'h0, 1'b1, 1'b0);
            else send_load(rand_base(), $urandom(), 1'b0, 1'b0);
            i++;
         end
         if (n_boot == 0) begin
            send_load(rand_base(), 32'h1, 1'b1, 1'b0);
            kind = 0;
         end else begin
            kind = $urandom_range(0, 2);
         end
         send_load(rand_base(), (kind == 0) ? 32'h1 : ((kind == 1) ? 32'h0 : $urandom()),
                   kind != 2, 1'b1);
      end

      // hold off until every outstanding result is back
      idle_sender();
      wait_drained();

      // metadata reservation that wraps the base past the top of memory
      send_load(rand_base(), $urandom(), 1'b0, 1'b0);
      send_load(64'hFFFF_FFFF_FFFF_E000, 32'h3, 1'b1, 1'b0);
      send_load(64'h0000_0000_0040_0000, 32'h2, 1'b1, 1'b1);
      send_alloc();

      while (items_sent < 1500) begin
         no_idle = (items_sent >= 700 && items_sent < 800);
         if (!big_placed && sb.run_count == MAX_REGIONS - 1) begin
            send_load(64'hFFFF_FFFF_FFFF_F000, 32'hFFFF_FFFF, 1'b1, 1'b0);
            big_placed = 1;
         end else begin
            kind = $urandom_range(0, 19);
            if (kind < 11) send_alloc();
            else if (kind < 15)
               send_load(rand_base(), $urandom_range(1, 8), 1'b1, $urandom_range(0, 7) == 0);
            else if (kind == 15)
               send_load(rand_base(), 32'h0, 1'b1, 1'($urandom_range(0, 1)));
            else
               send_load(rand_base(), $urandom(), 1'b0, 1'($urandom_range(0, 1)));
         end
      end
      no_idle = 0;

      idle_sender();
      wait_drained();
      repeat (2 * MAX_REGIONS) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_rsp.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ----- first_fit_page_allocator.f -----
+incdir+design
design/ffpa_pkg.sv
design/ffpa_cell.sv
design/first_fit_page_allocator.sv
tb/sv/tb.sv
